/* sv/assert_macros.svh */
// Assertion helpers. Both sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* sv/tgpg_pkg.sv */
package tgpg_pkg;

  localparam int unsigned GLYPH_ADDR_W = 12;
  localparam int unsigned GLYPH_DEPTH  = 4096;
  localparam int unsigned PAL_IDX_W    = 4;
  localparam int unsigned PAL_DEPTH    = 16;
  localparam int unsigned COLOR_W      = 24;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_RENDER   = 2'd0,
    FUNC_GLYPH_WR = 2'd1,
    FUNC_PAL_WR   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_GFX  = 2'd2
  } mode_e;

  typedef enum logic [0:0] {
    REG_VIDEO_MODE = 1'd0
  } reg_idx_e;

  localparam logic [COLOR_W-1:0] DEFAULT_PALETTE [PAL_DEPTH] = '{
    24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
    24'haa0000, 24'haa0088, 24'haaaa00, 24'haaaaaa,
    24'h888888, 24'h0000ff, 24'h00ff00, 24'h00ffff,
    24'hff0000, 24'hff00ff, 24'hffff00, 24'hffffff
  };

  typedef struct packed {
    logic [1:0]              func;
    logic [7:0]              code;
    logic [7:0]              attribute;
    logic [3:0]              glyph_row;
    logic                    blink_phase;
    logic [GLYPH_ADDR_W-1:0] write_index;
    logic [COLOR_W-1:0]      write_data;
  } in_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } out_req_t;

  // One classified render op: a row of pixel bits and its two colours.
  // Graphics ops use bits 8'h80, so pixel 0 takes col_on and pixel 1 col_off.
  typedef struct packed {
    logic               gfx;
    logic               hide;
    logic [7:0]         bits;
    logic [COLOR_W-1:0] col_on;
    logic [COLOR_W-1:0] col_off;
  } op_t;

endpackage

/* sv/tgpg_front.sv */
module tgpg_front import tgpg_pkg::*; #(
  parameter int unsigned GLYPH_HEIGHT = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_req_t               in_req_i,
  input  logic [1:0]            mode_i,
  input  logic [FIFO_CNT_W-1:0] fifo_cnt_i,
  output logic                  push_o,
  output op_t                   push_op_o
);

  localparam logic [GLYPH_ADDR_W-1:0] GlyphStride = GLYPH_ADDR_W'(GLYPH_HEIGHT);

  logic [7:0]         glyph_mem [GLYPH_DEPTH];
  logic [COLOR_W-1:0] pal_mem   [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] pal_valid_q;

  logic                    accept;
  logic                    glyph_wr, pal_wr, render_text, render_gfx;
  logic [GLYPH_ADDR_W-1:0] glyph_addr;
  logic [PAL_IDX_W-1:0]    idx_on, idx_off, pal_widx;

  logic               s1_push_q;
  logic               s1_gfx_q, s1_hide_q;
  logic [7:0]         glyph_q;
  logic [COLOR_W-1:0] col_on_q, col_off_q;

  // a request slot is reserved for the op still in the read stage
  assign in_ready_o = (fifo_cnt_i + FIFO_CNT_W'(s1_push_q)) < FIFO_CNT_W'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    glyph_wr    = 1'b0;
    pal_wr      = 1'b0;
    render_text = 1'b0;
    render_gfx  = 1'b0;
    case (func_e'(in_req_i.func))
      FUNC_GLYPH_WR: glyph_wr = 1'b1;
      FUNC_PAL_WR:   pal_wr = (in_req_i.write_index < GLYPH_ADDR_W'(PAL_DEPTH));
      FUNC_RENDER: begin
        case (mode_e'(mode_i))
          MODE_TEXT: render_text = 1'b1;
          MODE_GFX:  render_gfx = 1'b1;
          default:   ;
        endcase
      end
      default: ;
    endcase
  end

  assign glyph_addr = GLYPH_ADDR_W'(in_req_i.code) * GlyphStride
                    + GLYPH_ADDR_W'(in_req_i.glyph_row);
  assign pal_widx   = in_req_i.write_index[PAL_IDX_W-1:0];
  assign idx_on     = render_gfx ? in_req_i.code[3:0] : in_req_i.attribute[3:0];
  assign idx_off    = render_gfx ? in_req_i.code[7:4] : {1'b0, in_req_i.attribute[6:4]};

  // glyph store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (accept && glyph_wr) begin
      glyph_mem[in_req_i.write_index] <= in_req_i.write_data[7:0];
    end
    if (accept && render_text) begin
      glyph_q <= glyph_mem[glyph_addr];
    end
  end

  // palette: one write, two registered reads, defaults until written
  always_ff @(posedge clk_i) begin
    if (accept && pal_wr) begin
      pal_mem[pal_widx] <= in_req_i.write_data;
    end
    if (accept) begin
      col_on_q  <= pal_valid_q[idx_on] ? pal_mem[idx_on] : DEFAULT_PALETTE[idx_on];
      col_off_q <= pal_valid_q[idx_off] ? pal_mem[idx_off] : DEFAULT_PALETTE[idx_off];
      s1_gfx_q  <= render_gfx;
      s1_hide_q <= in_req_i.attribute[7] && in_req_i.blink_phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_valid_q <= '0;
      s1_push_q   <= 1'b0;
    end else begin
      if (accept && pal_wr) begin
        pal_valid_q[pal_widx] <= 1'b1;
      end
      s1_push_q <= accept && (render_text || render_gfx);
    end
  end

  assign push_o            = s1_push_q;
  assign push_op_o.gfx     = s1_gfx_q;
  assign push_op_o.hide    = s1_gfx_q ? 1'b0 : s1_hide_q;
  assign push_op_o.bits    = s1_gfx_q ? 8'h80 : glyph_q;
  assign push_op_o.col_on  = col_on_q;
  assign push_op_o.col_off = col_off_q;

endmodule

/* sv/tgpg_fifo.sv */
`include "assert_macros.svh"

module tgpg_fifo import tgpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  op_t                   push_op_i,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output op_t                   head_op_o,
  output logic [FIFO_CNT_W-1:0] cnt_o
);

  op_t                   slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                             : wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                             : rd_ptr_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
    end
  end

  assign head_valid_o = (cnt_q != '0);
  assign head_op_o    = slot_q[rd_ptr_q];
  assign cnt_o        = cnt_q;

  `ASSERT_NEVER(a_no_overflow, push_i && !pop_i && cnt_q == FIFO_CNT_W'(FIFO_DEPTH), "op queue overflow")
  `ASSERT_NEVER(a_no_underflow, pop_i && cnt_q == '0, "op queue underflow")

endmodule

/* sv/tgpg_back.sv */
`include "assert_macros.svh"

module tgpg_back import tgpg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     head_valid_i,
  input  op_t      head_op_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_req_t out_req_o
);

  logic [2:0] pix_cnt_q, pix_cnt_d;
  logic       out_valid_q, out_valid_d;
  out_req_t   out_q, out_d;
  logic       load, pix_bit;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  // leftmost pixel is bit 7
  assign pix_bit = head_op_i.bits[~pix_cnt_q];

  always_comb begin
    out_d.color = (pix_bit && !head_op_i.hide) ? head_op_i.col_on : head_op_i.col_off;
    out_d.last  = head_op_i.gfx ? (pix_cnt_q == 3'd1) : (pix_cnt_q == 3'd7);
    pop_o       = load && out_d.last;
    pix_cnt_d   = pix_cnt_q;
    if (load) begin
      pix_cnt_d = out_d.last ? 3'd0 : pix_cnt_q + 3'd1;
    end
    out_valid_d = load ? 1'b1 : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pix_cnt_q   <= pix_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `ASSERT_CLK(a_gfx_two_pix, head_valid_i && head_op_i.gfx |-> pix_cnt_q <= 3'd1, "graphics op beyond two pixels")
  `ASSERT_CLK(a_cnt_restart, pop_o |=> pix_cnt_q == 3'd0, "pixel count not restarted after last pixel")

endmodule

/* sv/text_graphics_pixel_generator.sv */
// Text / packed-graphics pixel generator.
// Input channel (in_valid_i / in_ready_o / in_req_i): each request is a render,
// a glyph store write or a palette write, chosen by func. Writes yield nothing.
// Output channel (out_valid_o / out_ready_i / out_req_o): one 24-bit colour per
// pixel, last set on the final pixel of a render.
// Text mode: 8 pixels per render, glyph bit 7 first. Graphics mode: 2 pixels,
// low nibble first. Display off (or mode 3): renders yield nothing.
// APB port: one register, video_mode, at byte address 0.
// The first pixel of a render passes the glyph/palette read stage, the op queue
// and the output register. The pixel sequencer in the back end gives one pixel
// per cycle while the receiver does not stall.
// A 4-deep op queue lets requests keep flowing while the receiver stalls;
// in_ready_o drops once it is full. A stalled pixel holds on the output.
// Reset: video_mode off, palette reads the default 16-colour table until
// written, queue empty. Glyph store is undefined until written.
module text_graphics_pixel_generator import tgpg_pkg::*; #(
  parameter int unsigned GLYPH_HEIGHT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_req_i,
  // pixel output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_req_t    out_req_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]            mode_q;
  logic                  cfg_wr;
  logic                  push, pop, head_valid;
  op_t                   push_op, head_op;
  logic [FIFO_CNT_W-1:0] fifo_cnt;

  // --- configuration register ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (reg_idx_e'(paddr[2]) == REG_VIDEO_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
    end else if (cfg_wr) begin
      mode_q <= pwdata[1:0];
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_VIDEO_MODE: prdata = {30'd0, mode_q};
      default:        prdata = 32'd0;
    endcase
  end

  // --- front: accept, memory access, classify ---
  tgpg_front #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_req_i  (in_req_i),
    .mode_i    (mode_q),
    .fifo_cnt_i(fifo_cnt),
    .push_o    (push),
    .push_op_o (push_op)
  );

  // --- op queue between front and back ---
  tgpg_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_op_i   (push_op),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_op_o   (head_op),
    .cnt_o       (fifo_cnt)
  );

  // --- back: pixel sequencer and output register ---
  tgpg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_op_i   (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
